>>> src/rmf_pkg.sv
package rmf_pkg;

  // Width of one sample word.
  localparam int SAMPLE_W = 32;

  // Width of the window length, ring slot and fill count.
  localparam int LEN_W = 4;

  // Default ring depth, handed to the top level's parameter.
  localparam int WIN_MAX_DEF = 15;

  // Shortest legal window and the length after reset.
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           slot;
    logic [LEN_W-1:0]           count;
  } item_t;

endpackage

>>> src/rmf_front.sv
module rmf_front #(
  parameter int WIN_MAX = rmf_pkg::WIN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_en,
  input  logic [rmf_pkg::LEN_W-1:0]        cfg_window_length,
  input  logic                             push,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                             in_clear_first,
  output logic                             full,
  output logic                             q_push,
  output rmf_pkg::item_t                   q_item,
  input  logic                             q_full,
  output logic [rmf_pkg::LEN_W-1:0]        win_len
);

  logic [rmf_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [rmf_pkg::LEN_W-1:0] pos_r, pos_nxt;
  logic [rmf_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic [rmf_pkg::LEN_W-1:0] base_pos;
  logic [rmf_pkg::LEN_W-1:0] base_cnt;
  logic [rmf_pkg::LEN_W-1:0] new_cnt;
  logic [rmf_pkg::LEN_W-1:0] pos_inc;
  logic [rmf_pkg::LEN_W-1:0] new_pos;
  logic                      len_ok;
  logic                      accept;

  // A length is taken only if it is odd and within the ring's range.
  assign len_ok = cfg_window_length[0] && (cfg_window_length >= rmf_pkg::LEN_MIN) &&
                  (int'(cfg_window_length) <= WIN_MAX);

  assign accept = push && !q_full;

  always_comb begin
    base_pos = in_clear_first ? '0 : pos_r;
    base_cnt = in_clear_first ? '0 : cnt_r;
    new_cnt  = (base_cnt < len_r) ? base_cnt + rmf_pkg::LEN_W'(1) : base_cnt;
    pos_inc  = base_pos + rmf_pkg::LEN_W'(1);
    new_pos  = (pos_inc >= len_r) ? '0 : pos_inc;
  end

  always_comb begin
    len_nxt = len_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (cfg_write_en && len_ok) begin
      len_nxt = cfg_window_length;
      pos_nxt = '0;
      cnt_nxt = '0;
    end else if (accept) begin
      pos_nxt = new_pos;
      cnt_nxt = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= rmf_pkg::LEN_RESET;
      pos_r <= '0;
      cnt_r <= '0;
    end else begin
      len_r <= len_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign full          = q_full;
  assign q_push        = accept;
  assign q_item.sample = in_sample;
  assign q_item.slot   = base_pos;
  assign q_item.count  = new_cnt;
  assign win_len       = len_r;

endmodule

>>> src/rmf_queue.sv
module rmf_queue #(
  parameter int DEPTH = rmf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rmf_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output rmf_pkg::item_t rd_item,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rmf_pkg::item_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr;
  logic               do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item = mem_r[rd_ptr_r];

endmodule

>>> src/rmf_back.sv
module rmf_back #(
  parameter int WIN_MAX = rmf_pkg::WIN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmf_pkg::item_t                      q_item,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic signed [rmf_pkg::SAMPLE_W-1:0] out_median,
  output logic [rmf_pkg::LEN_W-1:0]           out_fill_count,
  input  logic                                out_pop
);

  localparam int LW    = rmf_pkg::LEN_W;
  localparam int CNT_W = LW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_CNT
  } state_t;

  state_t                              state_r, state_nxt;
  logic signed [rmf_pkg::SAMPLE_W-1:0] store_r [WIN_MAX];
  logic [LW-1:0]                       cur_cnt_r, cur_cnt_nxt;
  logic [LW-1:0]                       cand_r, cand_nxt;
  logic signed [rmf_pkg::SAMPLE_W-1:0] cval_r, cval_nxt;
  logic [WIN_MAX-1:0]                  lt_r, lt_nxt;
  logic [WIN_MAX-1:0]                  le_r, le_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [rmf_pkg::SAMPLE_W-1:0] out_med_r, out_med_nxt;
  logic [LW-1:0]                       out_cnt_r, out_cnt_nxt;
  logic signed [rmf_pkg::SAMPLE_W-1:0] cand_val;
  logic [CNT_W-1:0]                    lt_num;
  logic [CNT_W-1:0]                    le_num;
  logic [CNT_W-1:0]                    rank;
  logic                                found;
  logic                                out_free;
  logic                                take;

  // Candidate value for the current rank test.
  always_comb begin
    cand_val = store_r[0];
    for (int j = 0; j < WIN_MAX; j++) begin
      if (int'(cand_r) == j) begin
        cand_val = store_r[j];
      end
    end
  end

  // Each held lane compares itself against the candidate.
  always_comb begin
    for (int j = 0; j < WIN_MAX; j++) begin
      lt_nxt[j] = (j < int'(cur_cnt_r)) && (store_r[j] < cand_val);
      le_nxt[j] = (j < int'(cur_cnt_r)) && (store_r[j] <= cand_val);
    end
  end

  // The candidate is the lower median if fewer than k+1 samples lie below it
  // and at least k+1 lie at or below it.
  assign lt_num   = CNT_W'($countones(lt_r));
  assign le_num   = CNT_W'($countones(le_r));
  assign rank     = CNT_W'((cur_cnt_r - LW'(1)) >> 1);
  assign found    = (lt_num <= rank) && (rank < le_num);
  assign out_free = !out_valid_r || out_pop;
  assign take     = (state_r == ST_IDLE) && !q_empty;
  assign q_pop    = take;

  always_comb begin
    state_nxt     = state_r;
    cur_cnt_nxt   = cur_cnt_r;
    cand_nxt      = cand_r;
    cval_nxt      = cval_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_med_nxt   = out_med_r;
    out_cnt_nxt   = out_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cur_cnt_nxt = q_item.count;
          cand_nxt    = '0;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP: begin
        cval_nxt  = cand_val;
        state_nxt = ST_CNT;
      end
      ST_CNT: begin
        if (found) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_med_nxt   = cval_r;
            out_cnt_nxt   = cur_cnt_r;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cand_nxt  = cand_r + LW'(1);
          state_nxt = ST_CMP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_cnt_r <= cur_cnt_nxt;
    cand_r    <= cand_nxt;
    cval_r    <= cval_nxt;
    out_med_r <= out_med_nxt;
    out_cnt_r <= out_cnt_nxt;
    if (state_r == ST_CMP) begin
      lt_r <= lt_nxt;
      le_r <= le_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < WIN_MAX; j++) begin
      if (take && (int'(q_item.slot) == j)) begin
        store_r[j] <= q_item.sample;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median     = out_med_r;
  assign out_fill_count = out_cnt_r;

endmodule

>>> src/running_median_filter.sv
// Sliding-window median filter. Each word pushed carries one signed 32-bit
// sample; it enters a ring window whose odd length (3 up to WIN_MAX, reset 3)
// is set through cfg_write_en and cfg_window_length, and each word yields one
// result: the lower median of the samples now held, together with how many
// samples that is. A set in_clear_first empties the window before the sample
// goes in. A length write that is even or out of range is dropped; an
// accepted one restarts the window empty, and it must be made while the
// filter holds no unfinished word. The front end tracks the ring slot and the
// fill count and queues each classified word in a two-entry queue; the back
// end writes the sample into its ring and then finds the median by testing
// the held samples one by one as candidates, comparing each against every
// lane in one state and counting the registered results in the next. The
// front keeps accepting words into the queue meanwhile until it is full, and
// a finished result waits in the output register without stopping the next
// search, which can only finish once that register is free.
module running_median_filter #(
  parameter int WIN_MAX = rmf_pkg::WIN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [rmf_pkg::LEN_W-1:0]           cfg_window_length,
  input  logic                                push,
  output logic                                full,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_clear_first,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [rmf_pkg::SAMPLE_W-1:0] out_median,
  output logic [rmf_pkg::LEN_W-1:0]           out_fill_count
);

  rmf_pkg::item_t            q_wr_item;
  rmf_pkg::item_t            q_rd_item;
  logic                      q_push;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_empty;
  logic                      out_valid;
  logic [rmf_pkg::LEN_W-1:0] win_len;

  // Front end: length register, ring slot and fill count bookkeeping.
  rmf_front #(
    .WIN_MAX(WIN_MAX)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_window_length(cfg_window_length),
    .push             (push),
    .in_sample        (in_sample),
    .in_clear_first   (in_clear_first),
    .full             (full),
    .q_push           (q_push),
    .q_item           (q_wr_item),
    .q_full           (q_full),
    .win_len          (win_len)
  );

  // Short queue that lets the front and the back stall independently.
  rmf_queue #(
    .DEPTH(rmf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_item(q_wr_item),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_item(q_rd_item),
    .empty  (q_empty)
  );

  // Back end: sample ring, candidate search and the output register.
  rmf_back #(
    .WIN_MAX(WIN_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (q_rd_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_median    (out_median),
    .out_fill_count(out_fill_count),
    .out_pop       (pop)
  );

  assign empty = !out_valid;

  // A shown result always reports at least one held sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_fill_count != '0))
  else $error("result shows an empty window");

  // A result that is not taken stays on the ports.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
  else $error("untaken result was dropped");

  // The front never hands the queue a word it has no room for.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
  else $error("queue overrun");

  // The fill count of a queued word never exceeds the window length.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wr_item.count <= win_len))
  else $error("fill count beyond window length");

endmodule

>>> tb/running_median_filter_tb.sv
`timescale 1ns / 100ps

module running_median_filter_tb;

  localparam int WIN_MAX  = rmf_pkg::WIN_MAX_DEF;
  localparam int SAMPLE_W = rmf_pkg::SAMPLE_W;
  localparam int LEN_W    = rmf_pkg::LEN_W;

  localparam logic [LEN_W-1:0] LEN_MIN   = rmf_pkg::LEN_MIN;
  localparam logic [LEN_W-1:0] LEN_RESET = rmf_pkg::LEN_RESET;

  // The stimulus stops once this many words have gone in.
  localparam int TOTAL_WORDS = 1750;

  // Cycles allowed for the back end to settle after the last result.
  localparam int SETTLE_CYCLES = 2 * WIN_MAX + 4;

  // Worst case per word is roughly the back end's full search, the longest
  // receiver stall and the longest sender gap. The limit is several times
  // the slowest legal run.
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum logic {ROW_WORD, ROW_LENGTH} row_kind_t;

  // One row of the opening sequence. A row either pushes a word or writes the
  // window length. Where has_value is set the expected result is written out
  // in the row itself; otherwise the window model supplies it.
  typedef struct packed {
    row_kind_t                  kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clear;
    logic [LEN_W-1:0]           length;
    logic                       has_value;
    logic signed [SAMPLE_W-1:0] median;
    logic [LEN_W-1:0]           fill;
  } opening_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [LEN_W-1:0]           fill;
  } filter_result_t;

  localparam int OPENING_ROWS = 32;

  // The first rows run in the reset window of three. They walk the warm-up,
  // the sample extremes, a clear, and then every kind of rejected length
  // write (even, zero, one) before a switch to the longest window. The long
  // window is then pushed past its length so that the ring wraps, with
  // repeated values so that ties show up in the ranking.
  localparam opening_row_t OPENING_SEQ [0:OPENING_ROWS-1] = '{
    '{ROW_WORD,   32'sd5,           1'b0, 4'd0,  1'b1, 32'sd5, 4'd1},
    '{ROW_WORD,   S_MIN,            1'b0, 4'd0,  1'b1, S_MIN,  4'd2},
    '{ROW_WORD,   S_MAX,            1'b0, 4'd0,  1'b1, 32'sd5, 4'd3},
    '{ROW_WORD,   32'sd0,           1'b0, 4'd0,  1'b1, 32'sd0, 4'd3},
    '{ROW_WORD,   -32'sd1,          1'b1, 4'd0,  1'b1, -32'sd1, 4'd1},
    '{ROW_WORD,   32'sh55555555,    1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'shAAAAAAAA,    1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_LENGTH, 32'sd0,           1'b0, 4'd4,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd7,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_LENGTH, 32'sd0,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_LENGTH, 32'sd0,           1'b0, 4'd1,  1'b0, 32'sd0, 4'd0},
    '{ROW_LENGTH, 32'sd0,           1'b0, 4'd2,  1'b0, 32'sd0, 4'd0},
    '{ROW_LENGTH, 32'sd0,           1'b0, 4'd15, 1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   S_MAX,            1'b0, 4'd0,  1'b1, S_MAX,  4'd1},
    '{ROW_WORD,   S_MIN,            1'b0, 4'd0,  1'b1, S_MIN,  4'd2},
    '{ROW_WORD,   -32'sd1,          1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd0,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd3,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd3,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd3,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   -32'sd3,          1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd100,         1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   -32'sd100,        1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd3,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sh7FFF0000,    1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sh80000001,    1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd42,          1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   -32'sd42,         1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd3,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   S_MAX,            1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_WORD,   32'sd0,           1'b0, 4'd0,  1'b0, 32'sd0, 4'd0},
    '{ROW_LENGTH, 32'sd0,           1'b0, 4'd13, 1'b0, 32'sd0, 4'd0}
  };

  // Every input starts at a known value.
  logic                       clk               = 1'b0;
  logic                       rst_n             = 1'b0;
  logic                       cfg_write_en      = 1'b0;
  logic [LEN_W-1:0]           cfg_window_length = LEN_RESET;
  logic                       push              = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample         = '0;
  logic                       in_clear_first    = 1'b0;
  logic                       pop               = 1'b0;
  logic                       full;
  logic                       empty;
  logic signed [SAMPLE_W-1:0] out_median;
  logic [LEN_W-1:0]           out_fill_count;

  // Our own copy of the window: the ring, the slot for the next sample, the
  // number of samples held and the configured length.
  logic signed [SAMPLE_W-1:0] ring_copy [WIN_MAX];
  logic [LEN_W-1:0]           length_copy = LEN_RESET;
  logic [LEN_W-1:0]           slot_copy   = '0;
  logic [LEN_W-1:0]           held_copy   = '0;

  // Results owed by the filter, oldest first.
  filter_result_t results_due [$];

  int words_sent     = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int stall_left     = 0;
  int calm_left      = 0;

  running_median_filter #(
    .WIN_MAX(WIN_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_window_length(cfg_window_length),
    .push             (push),
    .full             (full),
    .in_sample        (in_sample),
    .in_clear_first   (in_clear_first),
    .empty            (empty),
    .pop              (pop),
    .out_median       (out_median),
    .out_fill_count   (out_fill_count)
  );

  always #5 clk = ~clk;

  // Ranks the held samples in signed order and picks the lower middle one.
  // Only slots 0..n-1 are read, and each of them was written since the last
  // time the window was emptied.
  function automatic logic signed [SAMPLE_W-1:0] lower_median_of(input logic [LEN_W-1:0] n);
    logic signed [SAMPLE_W-1:0] ranked [WIN_MAX];
    logic signed [SAMPLE_W-1:0] key;
    int j;
    for (int i = 0; i < int'(n); i++) ranked[i] = ring_copy[i];
    for (int i = 1; i < int'(n); i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    return ranked[(int'(n) - 1) / 2];
  endfunction

  // A length write takes effect only if it is odd and in range; an accepted
  // one restarts the window empty, a rejected one leaves everything alone.
  task automatic write_length(input logic [LEN_W-1:0] value);
    cfg_write_en      <= 1'b1;
    cfg_window_length <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (value >= LEN_MIN && value[0] && int'(value) <= WIN_MAX) begin
      length_copy = value;
      slot_copy   = '0;
      held_copy   = '0;
    end
  endtask

  // Offers one word and waits until the filter takes it. Push is left high on
  // return so that a following word can go in on the very next cycle. The
  // expected result is queued at the accepting edge: the row's own value if
  // it carries one, otherwise the window model's.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] sample, input logic clear,
                           input logic has_value, input filter_result_t stated);
    filter_result_t predicted;
    push           <= 1'b1;
    in_sample      <= sample;
    in_clear_first <= clear;
    do @(posedge clk); while (full);
    if (clear) begin
      slot_copy = '0;
      held_copy = '0;
    end
    if (held_copy < length_copy) held_copy = held_copy + 1'b1;
    ring_copy[slot_copy] = sample;
    slot_copy = slot_copy + 1'b1;
    if (slot_copy >= length_copy) slot_copy = '0;
    predicted.median = lower_median_of(held_copy);
    predicted.fill   = held_copy;
    results_due.push_back(has_value ? stated : predicted);
    words_sent++;
  endtask

  // Mostly no gap, now and then a few idle cycles, rarely a long pause; none in a burst.
  task automatic sender_gap(input bit burst);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (!burst) begin
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender back until every owed result has been taken, then lets
  // the back end settle. Length writes are only made from this idle state.
  task automatic wait_idle();
    push <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random samples lean toward full-range values but also hit the extremes
  // and a narrow band around zero, where ties in the ranking are common.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0:       return S_MIN;
        1:       return S_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    if (roll <= 3) return $signed(SAMPLE_W'($urandom_range(0, 8))) - 4;
    return $signed(SAMPLE_W'($urandom));
  endfunction

  // Result side: takes results when pop is high and checks each one against
  // the oldest owed result, then decides pop for the next cycle. Values read
  // here are those from before the edge, since all drives are nonblocking.
  always @(posedge clk) begin : result_side
    filter_result_t want;
    int roll;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %0d: median %0d fill %0d", results_seen,
                     out_median, out_fill_count);
        end else begin
          want = results_due.pop_front();
          if (out_median !== want.median || out_fill_count !== want.fill) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected median %0d fill %0d, got median %0d fill %0d",
                       results_seen, want.median, want.fill, out_median, out_fill_count);
          end
        end
      end
      // Stalls are mostly short, now and then long, with calm stretches in
      // which every result is taken at once.
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
        calm_left--;
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (roll < 2) begin
        calm_left = $urandom_range(50, 300);
        pop <= 1'b1;
      end else if (roll < 14) begin
        stall_left = $urandom_range(0, 2);
        pop <= 1'b0;
      end else if (roll < 16) begin
        stall_left = $urandom_range(10, 40);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    filter_result_t stated;
    logic [LEN_W-1:0] length_pick;
    int phase;
    int run_length;
    bit burst;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening sequence from the table.
    for (int r = 0; r < OPENING_ROWS; r++) begin
      if (OPENING_SEQ[r].kind == ROW_LENGTH) begin
        wait_idle();
        write_length(OPENING_SEQ[r].length);
      end else begin
        stated.median = OPENING_SEQ[r].median;
        stated.fill   = OPENING_SEQ[r].fill;
        send_word(OPENING_SEQ[r].sample, OPENING_SEQ[r].clear, OPENING_SEQ[r].has_value,
                  stated);
        sender_gap(1'b0);
      end
    end

    // Random phases. Each one drains the filter, writes a new length (the
    // shortest and the longest window come round regularly, and about a quarter
    // of the other writes take any value, so many are rejected), then
    // streams a run of words with an occasional clear.
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      wait_idle();
      if (phase % 6 == 0) length_pick = LEN_MIN;
      else if (phase % 6 == 1) length_pick = LEN_W'(WIN_MAX);
      else if ($urandom_range(0, 3) == 0) length_pick = LEN_W'($urandom_range(0, 15));
      else length_pick = LEN_W'(2 * $urandom_range(1, (WIN_MAX - 1) / 2) + 1);
      write_length(length_pick);
      burst      = ($urandom_range(0, 3) == 0);
      run_length = $urandom_range(10, 120);
      for (int k = 0; k < run_length && words_sent < TOTAL_WORDS; k++) begin
        send_word(random_sample(), ($urandom_range(0, 40) == 0), 1'b0, stated);
        sender_gap(burst);
      end
      phase++;
    end

    // Wait for the last results and watch a little longer for strays.
    wait_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rmf_pkg.sv
src/rmf_front.sv
src/rmf_queue.sv
src/rmf_back.sv
src/running_median_filter.sv
tb/running_median_filter_tb.sv
